// ===== hw/rtl/dcrc_pkg.sv =====
// Shared types, constants and CRC helpers for the dual-order CRC-16 checker.
package dcrc_pkg;

    localparam logic [15:0] CRC_POLY = 16'h8005;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // One input beat as it travels from the input stage to the core.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] reference_crc;
    } t_beat;

    function automatic logic [7:0] flip8(input logic [7:0] v);
        logic [7:0] r;
        for (int k = 0; k < 8; k++) begin
            r[k] = v[7 - k];
        end
        return r;
    endfunction

    function automatic logic [15:0] flip16(input logic [15:0] v);
        logic [15:0] r;
        for (int k = 0; k < 16; k++) begin
            r[k] = v[15 - k];
        end
        return r;
    endfunction

    // Eight unrolled MSB-first steps of the 0x8005 CRC.
    function automatic logic [15:0] crc_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] a;
        logic        fb;
        a = acc;
        for (int k = 7; k >= 0; k--) begin
            fb = a[15] ^ b[k];
            a  = {a[14:0], 1'b0};
            if (fb) begin
                a = a ^ CRC_POLY;
            end
        end
        return a;
    endfunction

endpackage

// ===== hw/rtl/dcrc_in_stage.sv =====
// Input register stage: captures one beat and holds it until the core takes it.
module dcrc_in_stage
    import dcrc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_beat      i_beat,
    output t_beat      o_beat,
    input  logic       i_take,
    output logic       o_valid
);

    logic  r_valid;
    logic  n_valid;
    t_beat r_beat;

    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_beat <= i_beat;
        end
    end

    assign o_beat  = r_beat;
    assign o_valid = r_valid;

endmodule

// ===== hw/rtl/dcrc_core.sv =====
// CRC core: both accumulators, the match compare and the result register.
module dcrc_core
    import dcrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_beat       i_beat,
    output logic        o_take,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_crc_msb_first,
    output logic [15:0] o_crc_reflected,
    output logic        o_ref_hit
);

    logic [15:0] r_acc_msb;
    logic [15:0] r_acc_refl;
    logic [15:0] n_acc_msb;
    logic [15:0] n_acc_refl;
    logic        r_out_valid;
    logic [15:0] r_crc_a;
    logic [15:0] r_crc_b;
    logic        r_hit;
    logic [15:0] w_crc_b;
    logic        w_out_free;

    // Result slot frees when empty or being drained this cycle.
    assign w_out_free = !r_out_valid || i_ready;
    // Non-last beats always go; a last beat waits for the result slot.
    assign o_take = i_valid && (!i_beat.last_byte || w_out_free);

    assign n_acc_msb  = crc_byte(r_acc_msb, i_beat.data_byte);
    assign n_acc_refl = crc_byte(r_acc_refl, flip8(i_beat.data_byte));
    assign w_crc_b    = flip16(n_acc_refl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_msb   <= CRC_INIT;
            r_acc_refl  <= CRC_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (o_take) begin
                if (i_beat.last_byte) begin
                    r_acc_msb  <= CRC_INIT;
                    r_acc_refl <= CRC_INIT;
                end else begin
                    r_acc_msb  <= n_acc_msb;
                    r_acc_refl <= n_acc_refl;
                end
            end
            if (o_take && i_beat.last_byte) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded only with a last beat
    always_ff @(posedge i_clk) begin
        if (o_take && i_beat.last_byte) begin
            r_crc_a <= n_acc_msb;
            r_crc_b <= w_crc_b;
            r_hit   <= (n_acc_msb == i_beat.reference_crc) ||
                       (w_crc_b == i_beat.reference_crc);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_crc_msb_first = r_crc_a;
    assign o_crc_reflected = r_crc_b;
    assign o_ref_hit       = r_hit;

endmodule

// ===== hw/rtl/dual_order_crc16_check.sv =====
// Top level of the dual-order CRC-16 checker.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------------------
//  in      | in  | i_valid / o_ready    | i_data_byte, i_last_byte, i_reference_crc
//  out     | out | o_valid / i_ready    | o_crc_msb_first, o_crc_reflected, o_ref_hit
//
// One beat per cycle sustained while the result slot is free. An accepted beat
// is held in the input register; the unrolled 8-bit CRC update and compare then
// load the result register, which drives o_valid.
// Reset (synchronous, active low) clears valids and both accumulators to zero.
// A stalled result holds only the last beat in the input register; non-last
// beats keep flowing into the accumulators.
module dual_order_crc16_check
    import dcrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [15:0] i_reference_crc,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_crc_msb_first,
    output logic [15:0] o_crc_reflected,
    output logic        o_ref_hit
);

    t_beat       w_in_beat;
    t_beat       w_stage_beat;
    logic        w_stage_valid;
    logic        w_take;

    assign w_in_beat = '{data_byte: i_data_byte, last_byte: i_last_byte,
                         reference_crc: i_reference_crc};

    // Input register: o_ready follows the core's take, so a held beat
    // frees the slot in the same cycle it moves on.
    dcrc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_beat  (w_in_beat),
        .o_beat  (w_stage_beat),
        .i_take  (w_take),
        .o_valid (w_stage_valid)
    );

    // Accumulators, compare and result register
    dcrc_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (w_stage_valid),
        .i_beat          (w_stage_beat),
        .o_take          (w_take),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_crc_msb_first (o_crc_msb_first),
        .o_crc_reflected (o_crc_reflected),
        .o_ref_hit       (o_ref_hit)
    );

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for the dual-order CRC-16 checker: directed table, then random messages.
`timescale 1ns / 1ps

module tb_top;
    import dcrc_pkg::*;

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        o_ready;
    logic [7:0]  i_data_byte     = 8'h00;
    logic        i_last_byte     = 1'b0;
    logic [15:0] i_reference_crc = 16'h0000;
    logic        o_valid;
    logic        i_ready         = 1'b0;
    logic [15:0] o_crc_msb_first;
    logic [15:0] o_crc_reflected;
    logic        o_ref_hit;

    always #5 i_clk = ~i_clk;

    dual_order_crc16_check dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_last_byte     (i_last_byte),
        .i_reference_crc (i_reference_crc),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_crc_msb_first (o_crc_msb_first),
        .o_crc_reflected (o_crc_reflected),
        .o_ref_hit       (o_ref_hit)
    );

    // ------------------------------------------------------------------
    // Predictor: two CRC-16 accumulators, same polynomial, one fed with
    // each byte as is (MSB first), one fed with each byte bit-reversed.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [15:0] msb_first;
        logic [15:0] reflected;
        logic        match;
    } t_crc_result;

    t_crc_result pending_crcs [$];   // CRC results still owed by the DUT
    logic [15:0] sum_msb = CRC_INIT; // running MSB-first accumulator
    logic [15:0] sum_rev = CRC_INIT; // running accumulator of reversed bytes

    int errors       = 0;
    int results_seen = 0;
    int beats_sent   = 0;

    function automatic logic [15:0] crc16_absorb(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] a;
        a = acc;
        for (int k = 7; k >= 0; k--) begin
            if (a[15] ^ b[k]) begin
                a = {a[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                a = {a[14:0], 1'b0};
            end
        end
        return a;
    endfunction

    function automatic logic [7:0] mirror8(input logic [7:0] b);
        logic [7:0] r;
        r = {<<{b}};
        return r;
    endfunction

    function automatic logic [15:0] mirror16(input logic [15:0] w);
        logic [15:0] r;
        r = {<<{w}};
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Typed rows carry a result readable at a glance;
    // the rest go through the predictor.
    // ------------------------------------------------------------------
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [15:0] ref_crc;
        logic        typed;
        logic [15:0] exp_msb;
        logic [15:0] exp_refl;
        logic        exp_match;
    } t_stim_row;

    localparam int N_DIRECTED = 25;

    t_stim_row directed_rows [N_DIRECTED] = '{
        // one-byte zero message straight after reset: both CRCs stay zero
        '{8'h00, 1'b1, 16'h0000, 1'b1, 16'h0000, 16'h0000, 1'b1},
        '{8'h00, 1'b1, 16'hFFFF, 1'b1, 16'h0000, 16'h0000, 1'b0},
        // single-byte extremes and lone bits
        '{8'hFF, 1'b1, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h80, 1'b1, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h01, 1'b1, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        // "123456789", reference equal to the reflected (ARC) check value
        '{8'h31, 1'b0, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h32, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h33, 1'b0, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h34, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h35, 1'b0, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h36, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h37, 1'b0, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h38, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h39, 1'b1, 16'hBB3D, 1'b1, 16'hFEE8, 16'hBB3D, 1'b1},
        // same message, reference equal to the MSB-first check value
        '{8'h31, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h32, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h33, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h34, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h35, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h36, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h37, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h38, 1'b0, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'h39, 1'b1, 16'hFEE8, 1'b1, 16'hFEE8, 16'hBB3D, 1'b1},
        // two-byte message, 0xA5 then 0xFF
        '{8'hA5, 1'b0, 16'hFFFF, 1'b0, 16'h0000, 16'h0000, 1'b0},
        '{8'hFF, 1'b1, 16'h0000, 1'b0, 16'h0000, 16'h0000, 1'b0}
    };

    // ------------------------------------------------------------------
    // Sender. A beat is presented with NBAs at a rising edge and held
    // until the edge where o_ready is seen high. The predictor runs on
    // the accepted beat right there, in order.
    // ------------------------------------------------------------------
    int burst_left = 0;

    task automatic offer_beat(input logic [7:0] data, input logic last,
                              input logic [15:0] ref_crc, input logic typed,
                              input t_crc_result typed_result);
        t_crc_result r;
        i_valid         <= 1'b1;
        i_data_byte     <= data;
        i_last_byte     <= last;
        i_reference_crc <= ref_crc;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        beats_sent++;
        sum_msb = crc16_absorb(sum_msb, data);
        sum_rev = crc16_absorb(sum_rev, mirror8(data));
        if (last) begin
            r.msb_first = sum_msb;
            r.reflected = mirror16(sum_rev);
            r.match     = (r.msb_first == ref_crc) || (r.reflected == ref_crc);
            pending_crcs.push_back(typed ? typed_result : r);
            sum_msb = CRC_INIT;
            sum_rev = CRC_INIT;
        end
    endtask

    // Bursts of random length; between bursts valid drops for a random gap.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 4);
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            // mostly short bursts, now and then a long stretch with no gaps
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(0, 12);
        end
    endtask

    initial begin
        t_stim_row   row;
        t_crc_result typed_r;
        t_crc_result none_r;
        int          len;
        logic [7:0]  data;
        logic [15:0] ref_crc;
        logic [15:0] cand_msb;
        logic [15:0] cand_refl;
        bit          drained;

        drained = 1'b0;
        none_r  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // directed table
        for (int i = 0; i < N_DIRECTED; i++) begin
            row               = directed_rows[i];
            typed_r.msb_first = row.exp_msb;
            typed_r.reflected = row.exp_refl;
            typed_r.match     = row.exp_match;
            offer_beat(row.data, row.last, row.ref_crc, row.typed, typed_r);
            pace_sender();
        end

        // random messages, mostly short; a few long ones
        while (beats_sent < 1600) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
            for (int j = 0; j < len; j++) begin
                case ($urandom_range(0, 7))
                    0:       data = 8'h00;
                    1:       data = 8'hFF;
                    default: data = 8'($urandom);
                endcase
                // reference on non-last beats is junk the DUT must ignore
                ref_crc = 16'($urandom);
                if (j == len - 1) begin
                    cand_msb  = crc16_absorb(sum_msb, data);
                    cand_refl = mirror16(crc16_absorb(sum_rev, mirror8(data)));
                    case ($urandom_range(0, 7))
                        0, 1:    ref_crc = cand_msb;
                        2, 3:    ref_crc = cand_refl;
                        // near miss: one bit off the MSB-first CRC
                        4:       ref_crc = cand_msb ^ (16'h0001 << $urandom_range(0, 15));
                        default: ;
                    endcase
                end
                offer_beat(data, j == len - 1, ref_crc, 1'b0, none_r);
                pace_sender();
            end
            // once mid-run: hold the input off until every result is back
            if (!drained && beats_sent >= 800) begin
                drained = 1'b1;
                i_valid <= 1'b0;
                do @(posedge i_clk); while (pending_crcs.size() != 0);
            end
        end

        i_valid <= 1'b0;
        while (pending_crcs.size() != 0) @(posedge i_clk);
        // extra edges afterwards catch any stray result
        repeat (8) @(posedge i_clk);

        if (errors == 0 && pending_crcs.size() == 0) begin
            $display("dual_order_crc16_check verification clean");
        end else begin
            $display("dual_order_crc16_check verification failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random pattern of ready stretches, coin-flip cycles and
    // stalls, plus one long hold-off so the input side backs up.
    // ------------------------------------------------------------------
    initial begin
        int  span;
        int  mode;
        bit  held_off;
        held_off = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!held_off && results_seen >= 60) begin
                held_off = 1'b1;
                i_ready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            mode = $urandom_range(0, 2);
            span = (mode == 2) ? $urandom_range(1, 20) : $urandom_range(10, 60);
            repeat (span) begin
                case (mode)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom);
                    default: i_ready <= 1'b0;
                endcase
                @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every output beat against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_crc_result want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pending_crcs.size() == 0) begin
                errors++;
                $display("%0t: unexpected result msb %h refl %h hit %b", $time,
                         o_crc_msb_first, o_crc_reflected, o_ref_hit);
            end else begin
                want = pending_crcs.pop_front();
                if (o_crc_msb_first !== want.msb_first) begin
                    errors++;
                    $display("%0t: crc_msb_first expected %h actual %h", $time,
                             want.msb_first, o_crc_msb_first);
                end
                if (o_crc_reflected !== want.reflected) begin
                    errors++;
                    $display("%0t: crc_reflected expected %h actual %h", $time,
                             want.reflected, o_crc_reflected);
                end
                if (o_ref_hit !== want.match) begin
                    errors++;
                    $display("%0t: ref_hit expected %b actual %b", $time,
                             want.match, o_ref_hit);
                end
            end
        end
    end

    // Watchdog, far beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("dual_order_crc16_check verification failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/dcrc_pkg.sv
hw/rtl/dcrc_in_stage.sv
hw/rtl/dcrc_core.sv
hw/rtl/dual_order_crc16_check.sv
sim/tb_top.sv
